// File: hdl/bmc_pkg.sv
package bmc_pkg;

  // store geometry defaults
  localparam int unsigned MaxWidthDef  = 256;
  localparam int unsigned MaxHeightDef = 256;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned CoordW = 8;
  localparam int unsigned ModeW  = 2;

  // commands
  localparam logic [CmdW-1:0] CmdWrite = 2'd0;
  localparam logic [CmdW-1:0] CmdRun   = 2'd1;
  localparam logic [CmdW-1:0] CmdRead  = 2'd2;

  // operation modes
  localparam logic [ModeW-1:0] ModeErode  = 2'd0;
  localparam logic [ModeW-1:0] ModeDilate = 2'd1;
  localparam logic [ModeW-1:0] ModeOpen   = 2'd2;
  localparam logic [ModeW-1:0] ModeClose  = 2'd3;

  // configuration register indexes
  localparam logic [1:0] RegOpMode = 2'd0;
  localparam logic [1:0] RegWidth  = 2'd1;
  localparam logic [1:0] RegHeight = 2'd2;

  localparam logic [CoordW-1:0] WidthReset  = 8'd13;
  localparam logic [CoordW-1:0] HeightReset = 8'd13;

  typedef enum logic [3:0] {
    StIdle,
    StRead,
    StReadOut,
    StPassRd,
    StPassCalc,
    StPassWr,
    StCopyRd,
    StCopyWr
  } bmc_state_e;

  // controller to datapath
  typedef struct packed {
    logic ld_cmd;      // capture command fields
    logic clr_scan;    // reset scan counters
    logic step_scan;   // advance scan counters
    logic tap_rd;      // issue read for a neighbour tap
    logic calc_cap;    // capture a tap value
    logic wr_result;   // write result store
    logic wr_copy;     // write frame store from result
    logic wr_pixel;    // write frame store from command
    logic rd_pixel;    // read frame store at command address
    logic erode;       // current pass is erosion
    logic strobe;      // present read data
  } bmc_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic in_frame;    // command address inside frame
    logic scan_last;   // scan at last pixel
    logic empty;       // zero size frame
    logic tap_last;    // last tap of a pixel captured
  } bmc_stat_t;

endpackage

// File: hdl/bmc_ram.sv
module bmc_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/bmc_datapath.sv
module bmc_datapath #(
  parameter int unsigned MaxWidth  = bmc_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = bmc_pkg::MaxHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bmc_pkg::bmc_ctrl_t            ctrl_i,
  output bmc_pkg::bmc_stat_t            stat_o,
  input  logic [bmc_pkg::CoordW-1:0]    frame_width_i,
  input  logic [bmc_pkg::CoordW-1:0]    frame_height_i,
  input  logic [bmc_pkg::CoordW-1:0]    pixel_row_i,
  input  logic [bmc_pkg::CoordW-1:0]    pixel_col_i,
  input  logic                          pixel_black_i,
  output logic                          read_black_o
);
  import bmc_pkg::*;

  localparam int unsigned ColW  = $clog2(MaxWidth);
  localparam int unsigned RowW  = $clog2(MaxHeight);
  localparam int unsigned AddrW = RowW + ColW;
  // row and column are concatenated, so the store spans the full address range
  localparam int unsigned Depth = 1 << AddrW;
  // coordinates wide enough for both the port and the store
  localparam int unsigned CW    = (CoordW > ColW ? CoordW : ColW) + 1;
  localparam int unsigned RW    = (CoordW > RowW ? CoordW : RowW) + 1;

  // effective size clamped to the store
  logic [CW-1:0] eff_w;
  logic [RW-1:0] eff_h;
  assign eff_w = (CW'(frame_width_i) < CW'(MaxWidth)) ? CW'(frame_width_i) : CW'(MaxWidth);
  assign eff_h = (RW'(frame_height_i) < RW'(MaxHeight)) ? RW'(frame_height_i)
                                                         : RW'(MaxHeight);

  // captured command
  logic [CoordW-1:0] row_q, col_q;
  logic              black_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_cmd) begin
      row_q   <= pixel_row_i;
      col_q   <= pixel_col_i;
      black_q <= pixel_black_i;
    end
  end

  assign stat_o.in_frame = (RW'(pixel_row_i) < eff_h) && (CW'(pixel_col_i) < eff_w);
  assign stat_o.empty    = (eff_w == '0) || (eff_h == '0);

  // scan counters
  logic [RowW-1:0] sr_q;
  logic [ColW-1:0] sc_q;
  logic [2:0]      tap_q;
  logic            last_c, last_r;
  assign last_c = (CW'(sc_q) + CW'(1)) == eff_w;
  assign last_r = (RW'(sr_q) + RW'(1)) == eff_h;
  assign stat_o.scan_last = last_c && last_r;
  assign stat_o.tap_last  = (tap_q == 3'd5);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q  <= '0;
      sc_q  <= '0;
      tap_q <= '0;
    end else if (ctrl_i.clr_scan) begin
      sr_q  <= '0;
      sc_q  <= '0;
      tap_q <= '0;
    end else if (ctrl_i.step_scan) begin
      tap_q <= '0;
      if (last_c) begin
        sc_q <= '0;
        sr_q <= sr_q + RowW'(1);
      end else begin
        sc_q <= sc_q + ColW'(1);
      end
    end else if (ctrl_i.tap_rd) begin
      tap_q <= tap_q + 3'd1;
    end
  end

  // neighbour tap selection: centre, up, down, left, right
  logic [RowW-1:0] tr;
  logic [ColW-1:0] tc;
  logic            tap_ok;
  always_comb begin
    tr     = sr_q;
    tc     = sc_q;
    tap_ok = 1'b1;
    case (tap_q)
      3'd1: begin
        tr     = sr_q - RowW'(1);
        tap_ok = (sr_q != '0);
      end
      3'd2: begin
        tr     = sr_q + RowW'(1);
        tap_ok = !last_r;
      end
      3'd3: begin
        tc     = sc_q - ColW'(1);
        tap_ok = (sc_q != '0);
      end
      3'd4: begin
        tc     = sc_q + ColW'(1);
        tap_ok = !last_c;
      end
      default: begin
      end
    endcase
  end

  // tap validity is registered alongside the read data
  logic ok_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.tap_rd) begin
      ok_q <= tap_ok;
    end
  end

  // accumulate taps
  logic fr_rdata, rs_rdata;
  logic acc_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.step_scan || ctrl_i.clr_scan) begin
      acc_q <= ctrl_i.erode;
    end else if (ctrl_i.calc_cap) begin
      if (ctrl_i.erode) begin
        acc_q <= acc_q & ok_q & fr_rdata;
      end else begin
        acc_q <= acc_q | (ok_q & fr_rdata);
      end
    end
  end

  // address muxing
  logic [AddrW-1:0] scan_addr, tap_addr, cmd_addr;
  assign scan_addr = {sr_q, sc_q};
  assign tap_addr  = {tr, tc};
  assign cmd_addr  = {RowW'(row_q), ColW'(col_q)};

  logic [AddrW-1:0] fr_raddr, fr_waddr;
  logic             fr_we, fr_wdata;
  assign fr_raddr = ctrl_i.rd_pixel ? cmd_addr : tap_addr;
  assign fr_we    = ctrl_i.wr_pixel || ctrl_i.wr_copy;
  assign fr_waddr = ctrl_i.wr_pixel ? cmd_addr : scan_addr;
  assign fr_wdata = ctrl_i.wr_pixel ? black_q : rs_rdata;

  bmc_ram #(.Width(1), .Depth(Depth)) u_frame (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  // result store, erosion forces border pixels white
  logic border;
  assign border = (sr_q == '0) || (sc_q == '0) || last_r || last_c;

  bmc_ram #(.Width(1), .Depth(Depth)) u_result (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.wr_result),
    .waddr_i (scan_addr),
    .wdata_i (acc_q & !(ctrl_i.erode && border)),
    .raddr_i (scan_addr),
    .rdata_o (rs_rdata)
  );

  assign read_black_o = ctrl_i.strobe & fr_rdata;

endmodule

// File: hdl/bmc_ctrl.sv
module bmc_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bmc_pkg::CmdW-1:0]    cmd_i,
  input  logic [bmc_pkg::ModeW-1:0]   op_mode_i,
  input  bmc_pkg::bmc_stat_t          stat_i,
  output bmc_pkg::bmc_ctrl_t          ctrl_o,
  output logic                        busy_o,
  output logic                        strobe_o
);
  import bmc_pkg::*;

  bmc_state_e state_q, state_d;
  logic       second_q, second_d;   // second pass of open or close
  logic       wr_q, wr_d;           // pending pixel write

  logic two_pass;
  assign two_pass = (op_mode_i == ModeOpen) || (op_mode_i == ModeClose);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      second_q <= 1'b0;
      wr_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
      wr_q     <= wr_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d  = state_q;
    second_d = second_q;
    wr_d     = 1'b0;
    ctrl_o   = '0;
    ctrl_o.wr_pixel = wr_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          ctrl_o.ld_cmd = 1'b1;
          case (cmd_i)
            CmdWrite: wr_d = stat_i.in_frame;
            CmdRun: begin
              if (!stat_i.empty) begin
                ctrl_o.clr_scan = 1'b1;
                second_d        = 1'b0;
                state_d         = StPassRd;
              end
            end
            CmdRead: begin
              if (stat_i.in_frame) state_d = StRead;
            end
            default: begin
            end
          endcase
        end
      end
      StRead: begin
        ctrl_o.rd_pixel = 1'b1;
        state_d         = StReadOut;
      end
      StReadOut: begin
        ctrl_o.strobe = 1'b1;
        state_d       = StIdle;
      end
      // issue one tap read per cycle until the last tap of a pixel, capture in the next cycle
      StPassRd: begin
        ctrl_o.tap_rd = 1'b1;
        state_d       = StPassCalc;
      end
      StPassCalc: begin
        ctrl_o.calc_cap = 1'b1;
        if (stat_i.tap_last) begin
          state_d = StPassWr;
        end else begin
          ctrl_o.tap_rd = 1'b1;
        end
      end
      StPassWr: begin
        ctrl_o.wr_result = 1'b1;
        if (stat_i.scan_last) begin
          ctrl_o.clr_scan = 1'b1;
          state_d         = StCopyRd;
        end else begin
          ctrl_o.step_scan = 1'b1;
          state_d          = StPassRd;
        end
      end
      StCopyRd: begin
        state_d = StCopyWr;
      end
      StCopyWr: begin
        ctrl_o.wr_copy = 1'b1;
        if (stat_i.scan_last) begin
          if (two_pass && !second_q) begin
            second_d        = 1'b1;
            ctrl_o.clr_scan = 1'b1;
            state_d         = StPassRd;
          end else begin
            state_d = StIdle;
          end
        end else begin
          ctrl_o.step_scan = 1'b1;
          state_d          = StCopyRd;
        end
      end
      default: state_d = StIdle;
    endcase
    // erosion on first pass of erode/open, second pass of close;
    // follows the next pass so the accumulator is seeded right
    case (op_mode_i)
      ModeErode:  ctrl_o.erode = 1'b1;
      ModeDilate: ctrl_o.erode = 1'b0;
      ModeOpen:   ctrl_o.erode = !second_d;
      ModeClose:  ctrl_o.erode = second_d;
      default:    ctrl_o.erode = 1'b0;
    endcase
  end

  assign busy_o   = (state_q != StIdle) || wr_q;
  assign strobe_o = ctrl_o.strobe;

endmodule

// File: hdl/binary_morphology_cross_top.sv
// channel  | direction | transfer condition
// command  | in        | start && !busy (cmd, pixel_row, pixel_col, pixel_black)
// result   | out       | read_black_valid_o, one cycle, read_black_o
// config   | in        | cfg_valid_i && cfg_ready_o (cfg_index_i, cfg_data_i)
//
// write and ignored commands are taken in idle; an in-frame write holds busy while its pixel write is pending
// read passes through StRead, which issues the store read, and StReadOut, which strobes the result
// run makes one pass over the frame, two for open and close, limited by the single
//   read port of the frame store (StPassRd and StPassCalc read five taps per pixel,
//   StPassWr writes the result, StCopyRd and StCopyWr copy it back)
// reset clears control and restores the configuration registers; stores are not cleared
// results cannot be stalled by the receiver
module binary_morphology_cross_top #(
  parameter int unsigned MaxWidth  = bmc_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = bmc_pkg::MaxHeightDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [bmc_pkg::CmdW-1:0]    cmd_i,
  input  logic [bmc_pkg::CoordW-1:0]  pixel_row_i,
  input  logic [bmc_pkg::CoordW-1:0]  pixel_col_i,
  input  logic                        pixel_black_i,
  output logic                        read_black_valid_o,
  output logic                        read_black_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [bmc_pkg::CoordW-1:0]  cfg_data_i
);
  import bmc_pkg::*;

  // configuration registers
  logic [ModeW-1:0]  op_mode_q;
  logic [CoordW-1:0] width_q, height_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_mode_q <= ModeErode;
      width_q   <= WidthReset;
      height_q  <= HeightReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegOpMode: op_mode_q <= cfg_data_i[ModeW-1:0];
        RegWidth:  width_q   <= cfg_data_i;
        RegHeight: height_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  bmc_ctrl_t ctrl;
  bmc_stat_t stat;
  logic      busy_w;

  bmc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start && !busy_w),
    .cmd_i     (cmd_i),
    .op_mode_i (op_mode_q),
    .stat_i    (stat),
    .ctrl_o    (ctrl),
    .busy_o    (busy_w),
    .strobe_o  (read_black_valid_o)
  );

  bmc_datapath #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .frame_width_i  (width_q),
    .frame_height_i (height_q),
    .pixel_row_i    (pixel_row_i),
    .pixel_col_i    (pixel_col_i),
    .pixel_black_i  (pixel_black_i),
    .read_black_o   (read_black_o)
  );

  assign busy = busy_w;

endmodule

// File: test/tb_binary_morphology_cross_top.sv
`timescale 1ns / 100ps

module tb_binary_morphology_cross_top;
  import bmc_pkg::*;

  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  localparam logic [1:0]      RegNone   = 2'd3;
  localparam int unsigned     StoreW    = 256;
  localparam int unsigned     IdleLimit = 200000;

  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic              black;
  } pixel_cmd_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [CmdW-1:0]   cmd_i = '0;
  logic [CoordW-1:0] pixel_row_i = '0;
  logic [CoordW-1:0] pixel_col_i = '0;
  logic              pixel_black_i = 1'b0;
  logic              read_black_valid_o;
  logic              read_black_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i = '0;
  logic [CoordW-1:0] cfg_data_i = '0;

  binary_morphology_cross_top i_dut (.*);

  always #1 clk_i = ~clk_i;

  // predicted frame contents and configuration
  bit          frame_q   [StoreW*StoreW];
  bit          scratch_q [StoreW*StoreW];
  logic [1:0]  mode_q = ModeErode;
  int unsigned wid_q = 32'(WidthReset);
  int unsigned hgt_q = 32'(HeightReset);

  pixel_cmd_t  pending_q [$];
  bit          read_exp_q [$];
  int unsigned err_cnt = 0;
  int unsigned items_done = 0;
  int unsigned reads_done = 0;
  int unsigned runs_done = 0;
  int unsigned idle_cnt = 0;
  bit          item_taken = 1'b0;
  bit          cfg_taken = 1'b0;
  int unsigned gap_cnt = 0;

  // one erosion or dilation pass over the frame, in place
  task automatic morph_pass(input bit is_erode);
    bit v;
    for (int r = 0; r < hgt_q; r++) begin
      for (int c = 0; c < wid_q; c++) begin
        if (is_erode) begin
          v = 1'b0;
          if (r != 0 && c != 0 && r + 1 < hgt_q && c + 1 < wid_q) begin
            v = frame_q[r*StoreW+c] & frame_q[(r-1)*StoreW+c] & frame_q[(r+1)*StoreW+c]
              & frame_q[r*StoreW+c-1] & frame_q[r*StoreW+c+1];
          end
        end else begin
          v = frame_q[r*StoreW+c];
          if (r != 0) v |= frame_q[(r-1)*StoreW+c];
          if (r + 1 < hgt_q) v |= frame_q[(r+1)*StoreW+c];
          if (c != 0) v |= frame_q[r*StoreW+c-1];
          if (c + 1 < wid_q) v |= frame_q[r*StoreW+c+1];
        end
        scratch_q[r*StoreW+c] = v;
      end
    end
    for (int r = 0; r < hgt_q; r++)
      for (int c = 0; c < wid_q; c++) frame_q[r*StoreW+c] = scratch_q[r*StoreW+c];
  endtask

  // update the predicted frame for one accepted command
  task automatic predict_cmd(input pixel_cmd_t it);
    bit in_frame;
    in_frame = it.row < hgt_q && it.col < wid_q;
    case (it.cmd)
      CmdWrite: if (in_frame) frame_q[it.row*StoreW+it.col] = it.black;
      CmdRun: begin
        runs_done++;
        case (mode_q)
          ModeErode:  morph_pass(1'b1);
          ModeDilate: morph_pass(1'b0);
          ModeOpen: begin
            morph_pass(1'b1);
            morph_pass(1'b0);
          end
          default: begin
            morph_pass(1'b0);
            morph_pass(1'b1);
          end
        endcase
      end
      CmdRead: if (in_frame) read_exp_q.push_back(frame_q[it.row*StoreW+it.col]);
      default: ;
    endcase
  endtask

  function automatic bit read_black_exp_empty();
    return read_exp_q.size() == 0;
  endfunction

  // sample transfers and check results
  always @(posedge clk_i) begin
    pixel_cmd_t it;
    if (rst_ni) begin
      if (start && !busy) begin
        it = '{cmd: cmd_i, row: pixel_row_i, col: pixel_col_i, black: pixel_black_i};
        predict_cmd(it);
        items_done++;
        item_taken = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegOpMode: mode_q = cfg_data_i[1:0];
          RegWidth:  wid_q = 32'(cfg_data_i);
          RegHeight: hgt_q = 32'(cfg_data_i);
          default: ;
        endcase
        cfg_taken = 1'b1;
      end
      if (read_black_valid_o) begin
        reads_done++;
        if (read_black_exp_empty()) begin
          $error("read_black: unexpected result %0b", read_black_o);
          err_cnt++;
        end else begin
          if (read_black_o !== read_exp_q[0]) begin
            $error("read_black: expected %0b, actual %0b", read_exp_q[0], read_black_o);
            err_cnt++;
          end
          void'(read_exp_q.pop_front());
        end
      end
      // watchdog on cycles without any transfer
      if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || read_black_valid_o)
        idle_cnt = 0;
      else
        idle_cnt++;
      if (idle_cnt >= IdleLimit) begin
        $display("watchdog: no transfer for %0d cycles", IdleLimit);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // command driver with random gaps
  always @(negedge clk_i) begin
    pixel_cmd_t it;
    int unsigned r;
    if (!start || item_taken) begin
      item_taken = 1'b0;
      if (gap_cnt > 0) begin
        gap_cnt--;
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        it = pending_q.pop_front();
        cmd_i         <= it.cmd;
        pixel_row_i   <= it.row;
        pixel_col_i   <= it.col;
        pixel_black_i <= it.black;
        start         <= 1'b1;
        r = $urandom_range(99);
        if (r < 65) gap_cnt = 0;
        else if (r < 95) gap_cnt = $urandom_range(3, 1);
        else gap_cnt = $urandom_range(40, 10);
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [CoordW-1:0] data);
    @(negedge clk_i);
    cfg_taken   = 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 1'b0;
    repeat ($urandom_range(3)) @(negedge clk_i);
  endtask

  // sender holds off until every expected read has come back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || start || busy || read_exp_q.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic push(input logic [1:0] c, input int r, input int col, input int b);
    pending_q.push_back('{cmd: c, row: r[7:0], col: col[7:0], black: b[0]});
  endtask

  // write every pixel of the frame so runs and reads see defined data
  task automatic fill_frame(input int w, input int h);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) push(CmdWrite, r, c, $urandom_range(1));
  endtask

  // random traffic for a frame of w x h: mostly inside it, some outside it or unused commands
  task automatic random_items(input int w, input int h, input int n, input int run_pct);
    int unsigned k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (w == 0 || h == 0 || k >= 90) begin
        if (w < 255 && $urandom_range(1))
          push($urandom_range(1) ? CmdWrite : CmdRead, $urandom_range(255),
               $urandom_range(255, w), $urandom_range(1));
        else if (h < 255)
          push($urandom_range(1) ? CmdWrite : CmdRead, $urandom_range(255, h),
               $urandom_range(255), $urandom_range(1));
        else
          push(CmdUnused, $urandom_range(255), $urandom_range(255), $urandom_range(1));
      end else if (k >= 90 - run_pct) begin
        push(CmdRun, $urandom_range(255), $urandom_range(255), $urandom_range(1));
      end else if (k < 40) begin
        push(CmdWrite, $urandom_range(h - 1), $urandom_range(w - 1), $urandom_range(1));
      end else begin
        push(CmdRead, $urandom_range(h - 1), $urandom_range(w - 1), $urandom_range(1));
      end
    end
  endtask

  task automatic read_all(input int w, input int h);
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) push(CmdRead, r, c, 0);
  endtask

  task automatic frame_phase(input logic [1:0] mode, input int w, input int h,
                             input int n, input int run_pct);
    wait_drained();
    cfg_write(RegOpMode, CoordW'(mode));
    cfg_write(RegNone, CoordW'($urandom_range(255)));
    cfg_write(RegHeight, h[7:0]);
    cfg_write(RegWidth, w[7:0]);
    if (w != 0 && h != 0) fill_frame(w, h);
    random_items(w, h, n, run_pct);
  endtask

  initial begin
    int w, h;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset size, corners, edges of fields, unused command, erosion
    fill_frame(int'(WidthReset), int'(HeightReset));
    push(CmdRead, 0, 0, 0);
    push(CmdRead, 12, 12, 0);
    push(CmdWrite, 13, 0, 1);
    push(CmdWrite, 0, 255, 1);
    push(CmdRead, 255, 255, 0);
    push(CmdRead, 12, 13, 0);
    push(CmdUnused, 255, 255, 1);
    push(CmdWrite, 6, 6, 1);
    push(CmdRun, 0, 0, 0);
    read_all(int'(WidthReset), int'(HeightReset));

    // random frames of small size, modes in turn
    for (int p = 0; p < 6; p++) begin
      w = $urandom_range(8, 1);
      h = $urandom_range(8, 1);
      frame_phase(2'(p % 4), w, h, 30, 10);
      read_all(w, h);
    end

    // size extremes and empty frames
    frame_phase(ModeClose, 255, 1, 20, 5);
    frame_phase(ModeOpen, 1, 255, 20, 5);
    frame_phase(ModeErode, 1, 1, 20, 20);
    frame_phase(ModeDilate, 0, 5, 20, 0);
    frame_phase(ModeErode, 7, 0, 20, 0);
    frame_phase(2'($urandom_range(3)), 3, 4, 40, 8);

    wait_drained();
    repeat (20) @(negedge clk_i);
    $display("covered %0d commands: %0d reads checked, %0d morphology runs",
             items_done, reads_done, runs_done);
    $display("all four modes over frame sizes from empty up to 255 pixels on a side");
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/bmc_pkg.sv
hdl/bmc_ram.sv
hdl/bmc_datapath.sv
hdl/bmc_ctrl.sv
hdl/binary_morphology_cross_top.sv
test/tb_binary_morphology_cross_top.sv
